// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the resampler checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

// Implication that is also checked during reset.
`define ASSERT_ANY(lbl, clk, ante, cons) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("unconditional implication failed");

`endif

// ----- rtl/core/lir_pkg.sv -----
// ----------------------------------------------------------------------------
// lir_pkg
// Types, constants and helpers shared by the linear interpolation resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lir_pkg;

	// Stream widths.
	localparam int SAMPLE_W = 16;
	localparam int RATE_W   = 18;
	localparam int FRAC_W   = 14;
	localparam int CNT_W    = 3;

	// Rates in hertz.
	localparam logic [RATE_W-1:0] OUT_RATE   = 18'd16000;
	localparam logic [RATE_W-1:0] TWO_SPANS  = 18'd32000;
	localparam logic [RATE_W-1:0] RATE_MIN   = 18'd8000;
	localparam logic [RATE_W-1:0] RATE_MAX   = 18'd192000;
	localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;

	// At most this many results come from one item.
	localparam int MAX_RESULTS = 4;

	// Command queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// Division by 16000: shift right by 7, then multiply by ceil(2^29 / 125).
	localparam int NUM_W       = 32;
	localparam int DIV_SHIFT   = 7;
	localparam int X_W         = 22;
	localparam int M_W         = 23;
	localparam int PROD_W      = X_W + M_W;
	localparam int RECIP_SHIFT = 29;
	localparam logic [M_W-1:0] RECIP_M = 23'd4294968;

	// One interpolation job: lower and upper neighbor, phase and flags.
	typedef struct packed {
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
		logic [FRAC_W-1:0]   phase;
		logic                last_of_run;
		logic                end_of_stream;
	} cmd_t;

	// Limit the configured rate to the supported range.
	function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
		logic [RATE_W-1:0] res;
		res = r;
		if (r < RATE_MIN) begin
			res = RATE_MIN;
		end else if (r > RATE_MAX) begin
			res = RATE_MAX;
		end
		return res;
	endfunction

endpackage

// ----- rtl/core/linear_interp_resampler_16k.sv -----
// ----------------------------------------------------------------------------
// linear_interp_resampler_16k
// The phase sequencer holds each accepted item and issues its jobs to the job
// queue, which feeds stages s1, s2, s3 and the output register. No new item is
// taken until the sequencer is through with the current one; a stream's last
// item also runs a tail. The datapath gives one result per cycle unless the
// output stalls. Reset clears the stream state and sets the rate to 44100.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_interp_resampler_16k (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lir_pkg::RATE_W-1:0]    source_rate,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lir_pkg::SAMPLE_W-1:0]  sample,
	input  logic                          last_input,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lir_pkg::SAMPLE_W-1:0]  out_sample,
	output logic                          last_of_run,
	output logic                          end_of_stream
);
	import lir_pkg::*;

	logic [RATE_W-1:0] source_rate_q;
	logic [RATE_W-1:0] rate_eff;
	logic              push_valid;
	logic              push_ready;
	cmd_t              push_cmd;
	logic              pop_valid;
	logic              pop_ready;
	cmd_t              pop_cmd;

	// Rate register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_rate_q <= RATE_RESET;
		end else if (cfg_valid) begin
			source_rate_q <= source_rate;
		end
	end

	assign rate_eff = clamp_rate(source_rate_q);

	// Phase sequencer.
	lir_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rate       (rate_eff),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.last_input (last_input),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// Job queue.
	lir_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// Interpolation datapath.
	lir_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_cmd       (pop_cmd),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_sample    (out_sample),
		.last_of_run   (last_of_run),
		.end_of_stream (end_of_stream)
	);

endmodule

// ----- rtl/core/lir_front.sv -----
// ----------------------------------------------------------------------------
// lir_front
// Accepts source samples, steps the output phase and issues one
// interpolation job per output sample into the command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lir_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lir_pkg::RATE_W-1:0]    rate,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lir_pkg::SAMPLE_W-1:0]  sample,
	input  logic                          last_input,
	output logic                          push_valid,
	input  logic                          push_ready,
	output lir_pkg::cmd_t                 push_cmd
);
	import lir_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SPAN  = 2'd1;
	localparam logic [1:0] ST_TAIL  = 2'd2;

	logic [1:0]          state_q;
	logic [SAMPLE_W-1:0] prev_q;
	logic [SAMPLE_W-1:0] cur_q;
	logic                have_q;
	logic                last_q;
	logic [RATE_W-1:0]   phase_q;
	logic [RATE_W-1:0]   rate_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                emit_ok;
	logic                room;
	logic                more;
	logic [RATE_W-1:0]   phase_nx;

	// Emission test and lookahead for the run flags.
	assign emit_ok  = (phase_q < OUT_RATE) && (cnt_q < CNT_W'(MAX_RESULTS));
	assign room     = cnt_q < CNT_W'(MAX_RESULTS - 1);
	assign phase_nx = phase_q + rate_q;

	always_comb begin
		if (state_q == ST_SPAN) begin
			more = room && ((phase_nx < OUT_RATE) || (last_q && (phase_nx < TWO_SPANS)));
		end else begin
			more = room && (phase_nx < OUT_RATE);
		end
	end

	// Job issued to the queue.
	assign in_ready               = (state_q == ST_IDLE);
	assign push_valid             = (state_q != ST_IDLE) && emit_ok;
	assign push_cmd.a             = (state_q == ST_SPAN) ? prev_q : cur_q;
	assign push_cmd.b             = cur_q;
	assign push_cmd.phase         = phase_q[FRAC_W-1:0];
	assign push_cmd.last_of_run   = !more;
	assign push_cmd.end_of_stream = last_q && !more;

	// Sequencer over the span to the new sample and the tail after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_q  <= '0;
			have_q  <= 1'b0;
			phase_q <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q <= '0;
						if (have_q) begin
							state_q <= ST_SPAN;
						end else begin
							phase_q <= '0;
							prev_q  <= sample;
							have_q  <= 1'b1;
							state_q <= last_input ? ST_TAIL : ST_IDLE;
						end
					end
				end
				ST_SPAN: begin
					if (emit_ok) begin
						if (push_ready) begin
							phase_q <= phase_nx;
							cnt_q   <= cnt_q + CNT_W'(1);
						end
					end else begin
						phase_q <= (phase_q >= OUT_RATE) ? (phase_q - OUT_RATE) : '0;
						prev_q  <= cur_q;
						have_q  <= 1'b1;
						state_q <= last_q ? ST_TAIL : ST_IDLE;
					end
				end
				ST_TAIL: begin
					if (emit_ok) begin
						if (push_ready) begin
							phase_q <= phase_nx;
							cnt_q   <= cnt_q + CNT_W'(1);
						end
					end else begin
						phase_q <= '0;
						prev_q  <= '0;
						have_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload captured at acceptance.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cur_q  <= sample;
			last_q <= last_input;
			rate_q <= rate;
		end
	end

endmodule

// ----- rtl/core/lir_queue.sv -----
// ----------------------------------------------------------------------------
// lir_queue
// Small command queue that decouples the phase sequencer from the
// interpolation datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lir_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  lir_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output lir_pkg::cmd_t pop_cmd
);
	import lir_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	// Occupancy flags and head of the queue.
	assign push_ready = (count_q != (QPTR_W + 1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage write.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/core/lir_back.sv -----
// ----------------------------------------------------------------------------
// lir_back
// Interpolation datapath: weighted sum, magnitude and scale, reciprocal
// multiply for the division by 16000, sign restore and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lir_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  lir_pkg::cmd_t                 pop_cmd,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lir_pkg::SAMPLE_W-1:0]  out_sample,
	output logic                          last_of_run,
	output logic                          end_of_stream
);
	import lir_pkg::*;

	logic                       advance;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [NUM_W-1:0]    num;
	logic        [NUM_W-1:0]    mag;
	logic        [PROD_W-1:0]   qm;
	logic        [SAMPLE_W-1:0] quo;

	logic                       v_s1, v_s2, v_s3;
	logic signed [NUM_W-1:0]    num_s1;
	logic        [X_W-1:0]      x_s2;
	logic                       neg_s2, neg_s3;
	logic        [PROD_W-1:0]   qm_s3;
	logic        [1:0]          flags_s1, flags_s2, flags_s3;

	logic                       out_valid_q;
	logic        [SAMPLE_W-1:0] out_sample_q;
	logic        [1:0]          flags_q;

	// The whole pipe moves when the output register is free or being taken.
	assign advance   = !out_valid_q || out_ready;
	assign pop_ready = advance;

	// Stage 1 input: a*16000 + phase*(b-a).
	assign diff = (SAMPLE_W + 1)'($signed(pop_cmd.b)) - (SAMPLE_W + 1)'($signed(pop_cmd.a));
	assign num  = NUM_W'($signed(pop_cmd.a)) * NUM_W'($signed(OUT_RATE))
	            + NUM_W'($signed({1'b0, pop_cmd.phase})) * NUM_W'(diff);

	// Stage 2 input: magnitude scaled down by 128.
	assign mag = num_s1[NUM_W-1] ? NUM_W'(-num_s1) : NUM_W'(num_s1);

	// Stage 3 input: multiply by the reciprocal of 125.
	assign qm = PROD_W'(x_s2) * PROD_W'(RECIP_M);

	// Output: quotient truncated toward zero.
	assign quo = qm_s3[RECIP_SHIFT +: SAMPLE_W];

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= pop_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (advance) begin
			num_s1       <= num;
			flags_s1     <= {pop_cmd.last_of_run, pop_cmd.end_of_stream};
			x_s2         <= mag[DIV_SHIFT +: X_W];
			neg_s2       <= num_s1[NUM_W-1];
			flags_s2     <= flags_s1;
			qm_s3        <= qm;
			neg_s3       <= neg_s2;
			flags_s3     <= flags_s2;
			out_sample_q <= neg_s3 ? (~quo + SAMPLE_W'(1)) : quo;
			flags_q      <= flags_s3;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_sample    = out_sample_q;
	assign last_of_run   = flags_q[1];
	assign end_of_stream = flags_q[0];

endmodule

// ----- rtl/core/lir_checker.sv -----
// ----------------------------------------------------------------------------
// lir_checker
// Port-level checks on the resampler output stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lir_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [lir_pkg::SAMPLE_W-1:0]  out_sample,
	input logic                          last_of_run,
	input logic                          end_of_stream
);
	import lir_pkg::*;

	logic [SAMPLE_W+1:0] out_word;

	// Payload of the output channel as one word.
	assign out_word = {out_sample, last_of_run, end_of_stream};

	// A stalled item keeps its payload.
	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word))

	// The final item of a stream also closes the run of its input.
	`ASSERT_IMP(a_eos_closes_run, clk, arst_n, out_valid && end_of_stream, last_of_run)

	// Nothing is offered on the cycle after a reset edge.
	`ASSERT_ANY(a_reset_quiet, clk, !arst_n, ##1 !out_valid)

	// The input is open for a new item on the cycle after a reset edge.
	`ASSERT_ANY(a_reset_ready, clk, !arst_n, ##1 in_ready)

endmodule

bind linear_interp_resampler_16k lir_checker u_lir_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_sample    (out_sample),
	.last_of_run   (last_of_run),
	.end_of_stream (end_of_stream)
);
